@@ rtl/core/day_keyed_tally_table_top_macros.svh @@
// Assertion macros for the day keyed tally table
`ifndef DAY_KEYED_TALLY_TABLE_TOP_MACROS_SVH
`define DAY_KEYED_TALLY_TABLE_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define DKTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property only while a result item is offered
`define DKTT_ASSERT_OUT(lbl, prop, msg) \
    `DKTT_ASSERT(lbl, stats.valid |-> (prop), msg)

`endif

@@ rtl/core/dktt_pkg.sv @@
package dktt_pkg;

    localparam int MAX_DAYS   = 32;
    localparam int IDX_W      = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;
    localparam int CNT_W      = $clog2(MAX_DAYS + 1);
    localparam int DATA_W     = 32;
    localparam int PM_W       = 10;
    localparam int RUN_W      = 6;
    localparam int PERMILLE   = 1000;
    localparam int PROD_W     = DATA_W + PM_W;
    localparam int DIV_CNT_W  = $clog2(PROD_W);

    // Commands from controller to datapath
    typedef struct packed {
        logic in_ready;
        logic idx_clr;
        logic idx_inc;
        logic rd_en;
        logic rec_add;
        logic rec_append;
        logic lk_init;
        logic lk_hit;
        logic lk_yest;
        logic best_init;
        logic best_step;
        logic mul;
        logic div_step;
        logic out_load;
    } dktt_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic accept;
        logic skip;
        logic idx_end;
        logic day_match;
        logic words_nz;
        logic look_zero;
        logic try_yest;
        logic div_done;
        logic out_busy;
    } dktt_stat_t;

endpackage

@@ rtl/core/dktt_ifs.sv @@
interface dktt_sess_if;
    logic        valid;
    logic        ready;
    logic [31:0] session_day;
    logic [31:0] word_count;
    logic [31:0] time_ms;
    logic [31:0] today_day;

    modport source (output valid, session_day, word_count, time_ms, today_day, input ready);
    modport sink (input valid, session_day, word_count, time_ms, today_day, output ready);
    modport monitor (input valid, ready, session_day, word_count, time_ms, today_day);
endinterface

interface dktt_stats_if;
    logic        valid;
    logic        ready;
    logic [31:0] today_words;
    logic [9:0]  goal_permille;
    logic        goal_met;
    logic [5:0]  current_run;
    logic [5:0]  longest_run;
    logic [5:0]  days_held;

    modport source (output valid, today_words, goal_permille, goal_met, current_run,
                    longest_run, days_held, input ready);
    modport sink (input valid, today_words, goal_permille, goal_met, current_run,
                  longest_run, days_held, output ready);
    modport monitor (input valid, ready, today_words, goal_permille, goal_met, current_run,
                     longest_run, days_held);
endinterface

@@ rtl/core/dktt_datapath.sv @@
module dktt_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                goal_wr_en,
    input  logic [31:0]         goal_wr_data,
    dktt_sess_if.sink           session,
    dktt_stats_if.source        stats,
    input  dktt_pkg::dktt_cmd_t cmd,
    output dktt_pkg::dktt_stat_t stat
);
    import dktt_pkg::*;

    // Bucket memories
    logic [DATA_W-1:0] day_mem   [MAX_DAYS];
    logic [DATA_W-1:0] words_mem [MAX_DAYS];
    logic [DATA_W-1:0] time_mem  [MAX_DAYS];

    logic [DATA_W-1:0]    goal_reg;
    logic [IDX_W-1:0]     head_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic                 out_valid_reg;

    logic [DATA_W-1:0]    sday_reg, words_in_reg, ms_reg, today_reg;
    logic [DATA_W-1:0]    look_day_reg, tw_reg, prev_reg;
    logic [CNT_W-1:0]     run_reg, best_reg, brun_reg;
    logic                 tried_reg, first_reg, have_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [IDX_W-1:0]     rd_addr_reg;
    logic [DATA_W-1:0]    rd_day_reg, rd_words_reg, rd_time_reg;

    logic [DATA_W-1:0]    o_words_reg;
    logic [PM_W-1:0]      o_pm_reg;
    logic                 o_met_reg;
    logic [RUN_W-1:0]     o_run_reg, o_best_reg, o_held_reg;

    logic                 accept;
    logic [IDX_W-1:0]     rd_addr, app_addr, wr_addr;
    logic                 mem_we;
    logic [DATA_W-1:0]    wr_day, wr_words, wr_time;
    logic [DATA_W:0]      div_trial;
    logic                 div_bit;
    logic [CNT_W-1:0]     brun_step;
    logic [PM_W-1:0]      pm_val;

    // Map a position in stored order onto the circular memory
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
        if (sum >= (CNT_W+1)'(MAX_DAYS))
        begin
            sum = sum - (CNT_W+1)'(MAX_DAYS);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign accept        = session.valid && cmd.in_ready;
    assign session.ready = cmd.in_ready;
    assign rd_addr       = phys(head_reg, idx_reg);
    assign app_addr      = phys(head_reg, count_reg);

    // Select the memory write
    always_comb
    begin
        mem_we   = cmd.rec_add || cmd.rec_append;
        wr_addr  = app_addr;
        wr_day   = sday_reg;
        wr_words = words_in_reg;
        wr_time  = ms_reg;
        if (cmd.rec_add)
        begin
            wr_addr  = rd_addr_reg;
            wr_day   = rd_day_reg;
            wr_words = rd_words_reg + words_in_reg;
            wr_time  = rd_time_reg + ms_reg;
        end
    end

    // Write and read the bucket memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            day_mem[wr_addr]   <= wr_day;
            words_mem[wr_addr] <= wr_words;
            time_mem[wr_addr]  <= wr_time;
        end
        if (cmd.rd_en)
        begin
            rd_day_reg   <= day_mem[rd_addr];
            rd_words_reg <= words_mem[rd_addr];
            rd_time_reg  <= time_mem[rd_addr];
            rd_addr_reg  <= rd_addr;
        end
    end

    // Control registers: goal, table pointers, scan index, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (goal_wr_en)
            begin
                goal_reg <= goal_wr_data;
            end
            if (cmd.rec_append)
            begin
                if (count_reg == CNT_W'(MAX_DAYS))
                begin
                    head_reg <= (head_reg == IDX_W'(MAX_DAYS - 1)) ? '0 : head_reg + 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (stats.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Divider trial subtract
    assign div_trial = {rem_reg, prod_reg[PROD_W-1]};
    assign div_bit   = (div_trial >= {1'b0, goal_reg});

    // Next value of the stored-order run
    assign brun_step = (have_reg && rd_day_reg == prev_reg + 1'b1) ? brun_reg + 1'b1
                                                                   : CNT_W'(1);

    // Capped per-mille
    assign pm_val = (goal_reg == '0 || prod_reg > PROD_W'(PERMILLE)) ? PM_W'(PERMILLE)
                                                                     : prod_reg[PM_W-1:0];

    // Item, lookup, run and divider registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sday_reg     <= session.session_day;
            words_in_reg <= session.word_count;
            ms_reg       <= session.time_ms;
            today_reg    <= session.today_day;
            look_day_reg <= session.session_day;
        end
        if (cmd.lk_init)
        begin
            look_day_reg <= today_reg;
            run_reg      <= '0;
            tried_reg    <= 1'b0;
            first_reg    <= 1'b1;
            tw_reg       <= '0;
        end
        if (cmd.lk_hit)
        begin
            first_reg <= 1'b0;
            if (first_reg)
            begin
                tw_reg <= rd_words_reg;
            end
            if (rd_words_reg != '0)
            begin
                run_reg      <= run_reg + 1'b1;
                look_day_reg <= look_day_reg - 1'b1;
            end
        end
        if (cmd.lk_yest)
        begin
            look_day_reg <= today_reg - 1'b1;
            tried_reg    <= 1'b1;
            first_reg    <= 1'b0;
        end
        if (cmd.best_init)
        begin
            best_reg <= '0;
            brun_reg <= '0;
            have_reg <= 1'b0;
        end
        if (cmd.best_step)
        begin
            if (rd_words_reg == '0)
            begin
                brun_reg <= '0;
                have_reg <= 1'b0;
            end
            else
            begin
                brun_reg <= brun_step;
                have_reg <= 1'b1;
                prev_reg <= rd_day_reg;
                if (brun_step > best_reg)
                begin
                    best_reg <= brun_step;
                end
            end
        end
        if (cmd.mul)
        begin
            prod_reg    <= PROD_W'(tw_reg) * PROD_W'(PERMILLE);
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg     <= div_bit ? DATA_W'(div_trial - {1'b0, goal_reg})
                                   : div_trial[DATA_W-1:0];
            prod_reg    <= {prod_reg[PROD_W-2:0], div_bit};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            o_words_reg <= tw_reg;
            o_pm_reg    <= pm_val;
            o_met_reg   <= (tw_reg >= goal_reg);
            o_run_reg   <= RUN_W'(run_reg);
            o_best_reg  <= RUN_W'(best_reg);
            o_held_reg  <= RUN_W'(count_reg);
        end
    end

    // Status to the controller
    assign stat.accept    = accept;
    assign stat.skip      = (sday_reg == '0) || (words_in_reg == '0 && ms_reg == '0);
    assign stat.idx_end   = (idx_reg == count_reg);
    assign stat.day_match = (rd_day_reg == look_day_reg);
    assign stat.words_nz  = (rd_words_reg != '0);
    assign stat.look_zero = (look_day_reg == '0);
    assign stat.try_yest  = (run_reg == '0) && !tried_reg && (today_reg != '0);
    assign stat.div_done  = (div_cnt_reg == DIV_CNT_W'(PROD_W - 1));
    assign stat.out_busy  = out_valid_reg && !stats.ready;

    // Result port
    assign stats.valid         = out_valid_reg;
    assign stats.today_words   = o_words_reg;
    assign stats.goal_permille = o_pm_reg;
    assign stats.goal_met      = o_met_reg;
    assign stats.current_run   = o_run_reg;
    assign stats.longest_run   = o_best_reg;
    assign stats.days_held     = o_held_reg;

endmodule

@@ rtl/core/dktt_controller.sv @@
module dktt_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dktt_pkg::dktt_stat_t stat,
    output dktt_pkg::dktt_cmd_t  cmd
);
    import dktt_pkg::*;

    typedef enum logic [15:0] {
        IDLE      = 16'h0001,
        REC_START = 16'h0002,
        REC_RD    = 16'h0004,
        REC_CMP   = 16'h0008,
        REC_APP   = 16'h0010,
        LK_INIT   = 16'h0020,
        LK_START  = 16'h0040,
        LK_RD     = 16'h0080,
        LK_CMP    = 16'h0100,
        LK_MISS   = 16'h0200,
        BEST_INIT = 16'h0400,
        BEST_RD   = 16'h0800,
        BEST_CMP  = 16'h1000,
        MUL       = 16'h2000,
        DIV       = 16'h4000,
        DONE      = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence record, lookups, run scan and divide
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.accept)
                begin
                    state_next = REC_START;
                end
            end
            REC_START:
            begin
                cmd.idx_clr = 1'b1;
                state_next  = stat.skip ? LK_INIT : REC_RD;
            end
            REC_RD:
            begin
                if (stat.idx_end)
                begin
                    state_next = REC_APP;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = REC_CMP;
                end
            end
            REC_CMP:
            begin
                if (stat.day_match)
                begin
                    cmd.rec_add = 1'b1;
                    state_next  = LK_INIT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = REC_RD;
                end
            end
            REC_APP:
            begin
                cmd.rec_append = 1'b1;
                state_next     = LK_INIT;
            end
            LK_INIT:
            begin
                cmd.lk_init = 1'b1;
                state_next  = LK_START;
            end
            LK_START:
            begin
                cmd.idx_clr = 1'b1;
                state_next  = stat.look_zero ? LK_MISS : LK_RD;
            end
            LK_RD:
            begin
                if (stat.idx_end)
                begin
                    state_next = LK_MISS;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = LK_CMP;
                end
            end
            LK_CMP:
            begin
                if (stat.day_match)
                begin
                    cmd.lk_hit = 1'b1;
                    state_next = stat.words_nz ? LK_START : LK_MISS;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = LK_RD;
                end
            end
            LK_MISS:
            begin
                if (stat.try_yest)
                begin
                    cmd.lk_yest = 1'b1;
                    state_next  = LK_START;
                end
                else
                begin
                    state_next = BEST_INIT;
                end
            end
            BEST_INIT:
            begin
                cmd.idx_clr   = 1'b1;
                cmd.best_init = 1'b1;
                state_next    = BEST_RD;
            end
            BEST_RD:
            begin
                if (stat.idx_end)
                begin
                    state_next = MUL;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = BEST_CMP;
                end
            end
            BEST_CMP:
            begin
                cmd.best_step = 1'b1;
                cmd.idx_inc   = 1'b1;
                state_next    = BEST_RD;
            end
            MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = DIV;
            end
            DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = DONE;
                end
            end
            DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/day_keyed_tally_table_top.sv @@
// Day keyed tally table: holds up to 32 day buckets in arrival order in a circular
// memory, adds each session into its day's bucket (or appends one, dropping the oldest
// when full) and returns one statistics item per session. The block takes one session
// at a time. The single memory read port serves the record search, one key search for
// each day of the current run plus today and yesterday, and the stored-order run scan;
// the per-mille divide that follows is a restoring shift-subtract divide. A result that
// is not taken stalls the next result until the receiver accepts it.
// The daily goal register may be written at any time the block is idle.
module day_keyed_tally_table_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         goal_wr_en,
    input  logic [31:0]  goal_wr_data,
    dktt_sess_if.sink    session,
    dktt_stats_if.source stats
);
    import dktt_pkg::*;

    dktt_cmd_t  cmd;
    dktt_stat_t stat;

    dktt_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    dktt_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .goal_wr_en   (goal_wr_en),
        .goal_wr_data (goal_wr_data),
        .session      (session),
        .stats        (stats),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

@@ rtl/core/dktt_checker.sv @@
`include "day_keyed_tally_table_top_macros.svh"

module dktt_checker (
    input logic          clk,
    input logic          rst_n,
    dktt_sess_if.sink    session,
    dktt_stats_if.source stats
);

    // Keep a stalled result offered
    `DKTT_ASSERT(a_out_hold, stats.valid && !stats.ready |=> stats.valid, "result dropped")

    // Take one session at a time
    `DKTT_ASSERT(a_one_item, session.valid && session.ready |=> !session.ready, "overlap")

    // Reaching the goal means full progress
    `DKTT_ASSERT_OUT(a_goal_full, !stats.goal_met || stats.goal_permille == 10'd1000, "goal")

    // Runs never exceed the buckets held
    `DKTT_ASSERT_OUT(a_cur_run, stats.current_run <= stats.days_held, "current run")
    `DKTT_ASSERT_OUT(a_best_run, stats.longest_run <= stats.days_held, "longest run")

endmodule

bind day_keyed_tally_table_top dktt_checker u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .session (session),
    .stats   (stats)
);

@@ tb/sv/tb_day_keyed_tally_table_top.sv @@
`timescale 1ns / 100ps

module tb_day_keyed_tally_table_top;
    import dktt_pkg::*;

    typedef struct packed {
        logic [31:0] session_day;
        logic [31:0] word_count;
        logic [31:0] time_ms;
        logic [31:0] today_day;
    } session_t;

    typedef struct packed {
        logic [31:0] today_words;
        logic [9:0]  goal_permille;
        logic        goal_met;
        logic [5:0]  current_run;
        logic [5:0]  longest_run;
        logic [5:0]  days_held;
    } tally_t;

    // One directed row: the item, the goal to write before it, and an optional typed result
    typedef struct {
        session_t    sess;
        logic        set_goal;
        logic [31:0] goal;
        logic        typed;
        tally_t      res;
    } row_t;

    localparam int CFG_GOAL   = 0;
    localparam int WATCHDOG   = 200000;
    localparam int DRAIN_WAIT = 3000;
    localparam int N_RANDOM   = 500;

    logic clk;
    logic rst_n;
    logic goal_wr_en;
    logic [31:0] goal_wr_data;

    dktt_sess_if  session ();
    dktt_stats_if stats ();

    day_keyed_tally_table_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .goal_wr_en   (goal_wr_en),
        .goal_wr_data (goal_wr_data),
        .session      (session),
        .stats        (stats)
    );

    // Predictor state
    logic [31:0] goal_q;
    logic [31:0] tbl_day   [MAX_DAYS];
    logic [31:0] tbl_words [MAX_DAYS];
    logic [31:0] tbl_time  [MAX_DAYS];
    int          tbl_count;

    tally_t      pending_tally[$];
    int          errors;
    int          idle_cnt;
    logic        no_idle;
    logic [31:0] day_base;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int find_bucket(logic [31:0] day);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_day[i] == day) return i;
        return -1;
    endfunction

    function automatic logic [31:0] words_of(logic [31:0] day);
        int at;
        at = find_bucket(day);
        if (day == 0 || at < 0) return 32'd0;
        return tbl_words[at];
    endfunction

    // Record the session, then compute today's statistics
    function automatic tally_t tally_session(session_t s);
        tally_t      r;
        int          at;
        logic [31:0] tw;
        logic [31:0] d;
        logic [31:0] prev;
        logic [63:0] pm;
        int          run;
        int          best;
        bit          have;
        if (s.session_day != 0 && (s.word_count != 0 || s.time_ms != 0)) begin
            at = find_bucket(s.session_day);
            if (at >= 0) begin
                tbl_words[at] += s.word_count;
                tbl_time[at]  += s.time_ms;
            end
            else begin
                if (tbl_count >= MAX_DAYS) begin
                    for (int i = 1; i < MAX_DAYS; i++) begin
                        tbl_day[i-1]   = tbl_day[i];
                        tbl_words[i-1] = tbl_words[i];
                        tbl_time[i-1]  = tbl_time[i];
                    end
                    tbl_count = MAX_DAYS - 1;
                end
                tbl_day[tbl_count]   = s.session_day;
                tbl_words[tbl_count] = s.word_count;
                tbl_time[tbl_count]  = s.time_ms;
                tbl_count++;
            end
        end
        tw = words_of(s.today_day);
        if (goal_q == 0) pm = 1000;
        else begin
            pm = ({32'd0, tw} * 64'd1000) / {32'd0, goal_q};
            if (pm > 1000) pm = 1000;
        end
        r.today_words   = tw;
        r.goal_permille = pm[9:0];
        r.goal_met      = (tw >= goal_q);
        // Current run, anchored at today or yesterday
        run = 0;
        if (s.today_day != 0 && tbl_count != 0) begin
            d = s.today_day;
            if (words_of(d) == 0) d = d - 1;
            for (int k = 0; k <= MAX_DAYS; k++) begin
                if (words_of(d) == 0) break;
                run++;
                if (d == 0) break;
                d = d - 1;
            end
        end
        r.current_run = run[5:0];
        // Longest run in stored order
        best = 0; run = 0; have = 0; prev = 0;
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_words[i] == 0) begin
                run = 0; have = 0;
            end
            else begin
                if (have && tbl_day[i] == prev + 32'd1) run++;
                else run = 1;
                if (run > best) best = run;
                prev = tbl_day[i];
                have = 1;
            end
        end
        r.longest_run = best[5:0];
        r.days_held   = tbl_count[5:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // Check each accepted result item against the oldest expectation
    always @(posedge clk) begin
        tally_t got;
        tally_t want;
        if (rst_n && stats.valid && stats.ready) begin
            got = '{stats.today_words, stats.goal_permille, stats.goal_met,
                    stats.current_run, stats.longest_run, stats.days_held};
            if (pending_tally.size() == 0) begin
                $display("unexpected result item at %0t", $realtime);
                errors++;
            end
            else begin
                want = pending_tally.pop_front();
                if (got.today_words != want.today_words)
                    report_mismatch("today_words", got.today_words, want.today_words);
                if (got.goal_permille != want.goal_permille)
                    report_mismatch("goal_permille", got.goal_permille, want.goal_permille);
                if (got.goal_met != want.goal_met)
                    report_mismatch("goal_met", got.goal_met, want.goal_met);
                if (got.current_run != want.current_run)
                    report_mismatch("current_run", got.current_run, want.current_run);
                if (got.longest_run != want.longest_run)
                    report_mismatch("longest_run", got.longest_run, want.longest_run);
                if (got.days_held != want.days_held)
                    report_mismatch("days_held", got.days_held, want.days_held);
            end
        end
    end

    // Receiver stalls at random, except during the quiet stretch
    always @(negedge clk) begin
        if (!rst_n) stats.ready <= 1'b0;
        else stats.ready <= no_idle || ($urandom_range(99) >= 20);
    end

    // Watchdog on cycles with no accepted item
    always @(posedge clk) begin
        if ((session.valid && session.ready) || (stats.valid && stats.ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG) begin
            $display("watchdog expired at %0t", $realtime);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_goal(logic [31:0] g);
        @(negedge clk);
        goal_wr_en   <= 1'b1;
        goal_wr_data <= g;
        @(negedge clk);
        goal_wr_en   <= 1'b0;
        goal_q = g;
    endtask

    task automatic wait_drained();
        while (pending_tally.size() != 0) @(negedge clk);
    endtask

    // Drive one session item; the predictor runs at acceptance
    task automatic send_session(session_t s, bit typed, tally_t res);
        tally_t pred;
        @(negedge clk);
        if (!no_idle)
            while ($urandom_range(99) < 20) @(negedge clk);
        session.valid       <= 1'b1;
        session.session_day <= s.session_day;
        session.word_count  <= s.word_count;
        session.time_ms     <= s.time_ms;
        session.today_day   <= s.today_day;
        @(posedge clk);
        while (!session.ready) @(posedge clk);
        pred = tally_session(s);
        if (typed && pred != res) begin
            $display("directed row disagrees with predictor at %0t", $realtime);
            errors++;
        end
        pending_tally.push_back(typed ? res : pred);
        @(negedge clk);
        session.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_amount();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF - $urandom_range(3);
            2: return $urandom();
            default: return $urandom_range(500);
        endcase
    endfunction

    function automatic logic [31:0] rand_goal();
        case ($urandom_range(3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(2000, 1);
        endcase
    endfunction

    function automatic session_t rand_session();
        session_t s;
        int mode;
        mode = $urandom_range(99);
        if (mode < 80) begin
            // Well-formed: sessions on days near a base, today nearby
            s.session_day = day_base + $urandom_range(40);
            s.word_count  = ($urandom_range(9) == 0) ? 32'd0 : rand_amount();
            s.time_ms     = rand_amount();
            s.today_day   = day_base + $urandom_range(42);
            if ($urandom_range(9) == 0) day_base = day_base + $urandom_range(20);
        end
        else begin
            s.session_day = ($urandom_range(4) == 0) ? 32'd0 : $urandom();
            s.word_count  = rand_amount();
            s.time_ms     = rand_amount();
            s.today_day   = ($urandom_range(4) == 0) ? 32'd0 : $urandom();
        end
        return s;
    endfunction

    row_t dir_rows[$];

    function automatic row_t mk(logic [31:0] sd, logic [31:0] wc, logic [31:0] tm,
                                logic [31:0] td, logic sg, logic [31:0] g,
                                logic ty, tally_t r);
        row_t x;
        x.sess = '{sd, wc, tm, td};
        x.set_goal = sg; x.goal = g; x.typed = ty; x.res = r;
        return x;
    endfunction

    initial begin
        tally_t none;
        session_t s;
        none = '0;
        errors = 0; tbl_count = 0; goal_q = 0; no_idle = 0; day_base = 32'd100;
        rst_n = 1'b0;
        goal_wr_en = 1'b0; goal_wr_data = '0;
        session.valid = 1'b0; session.session_day = '0; session.word_count = '0;
        session.time_ms = '0; session.today_day = '0;
        stats.ready = 1'b0;
        for (int i = 0; i < MAX_DAYS; i++) begin
            tbl_day[i] = 0; tbl_words[i] = 0; tbl_time[i] = 0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        dir_rows.push_back(mk(0, 5, 5, 0, 0, 0, 1, '{0, 1000, 1, 0, 0, 0}));
        dir_rows.push_back(mk(7, 0, 0, 7, 0, 0, 1, '{0, 1000, 1, 0, 0, 0}));
        dir_rows.push_back(mk(1, 10, 0, 1, 0, 0, 1, '{10, 1000, 1, 1, 1, 1}));
        dir_rows.push_back(mk(2, 0, 50, 2, 0, 0, 0, none));
        dir_rows.push_back(mk(3, 30, 1, 3, 1, 100, 0, none));
        dir_rows.push_back(mk(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4, 0, 0, 0, none));
        dir_rows.push_back(mk(4, 1, 1, 4, 0, 0, 0, none));
        dir_rows.push_back(mk(5, 200, 0, 6, 0, 0, 0, none));
        dir_rows.push_back(mk(6, 99, 0, 0, 0, 0, 0, none));
        dir_rows.push_back(mk(32'hFFFF_FFFF, 3, 3, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, none));
        dir_rows.push_back(mk(1, 1, 0, 1, 0, 0, 0, none));
        dir_rows.push_back(mk(2, 32'hFFFF_FFFF, 0, 2, 1, 1, 0, none));
        for (int i = 0; i < 12; i++)
            dir_rows.push_back(mk(10 + i, i + 1, 0, 10 + i, 0, 0, 0, none));
        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_goal) begin
                wait_drained();
                repeat (DRAIN_WAIT) @(negedge clk);
                write_goal(dir_rows[i].goal);
            end
            send_session(dir_rows[i].sess, dir_rows[i].typed, dir_rows[i].res);
        end

        // Random phases with goal changes between them
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 50) begin
                wait_drained();
                repeat (DRAIN_WAIT) @(negedge clk);
                write_goal(rand_goal());
            end
            no_idle = (n >= 200 && n < 260);
            s = rand_session();
            send_session(s, 1'b0, none);
        end
        no_idle = 0;

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (errors == 0 && pending_tally.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
